@@ rtl/cpr_pkg.sv @@
// shared types and constants for the clock page replacement block
// no dependencies; imported by cpr_frame_table, cpr_ctrl and the top level
`default_nettype none

package cpr_pkg;

  localparam int FRAMES = 32;
  localparam int HAND_W = $clog2(FRAMES);
  localparam int FUNC_W = 3;
  localparam int IDX_W  = 5;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  // request codes on the input channel
  typedef enum logic [FUNC_W-1:0] {
    FN_REPLACE   = 3'd0,
    FN_REFERENCE = 3'd1,
    FN_DIRTY     = 3'd2,
    FN_CLEANED   = 3'd3,
    FN_RELEASE   = 3'd4
  } func_t;

  // frame table write commands
  typedef enum logic [2:0] {
    TBL_NONE,
    TBL_SET_VALID,
    TBL_SET_DIRTY,
    TBL_CLR_DIRTY,
    TBL_RELEASE,
    TBL_CLR_VALID,
    TBL_LOAD
  } tbl_cmd_t;

  typedef struct packed {
    tbl_cmd_t          cmd;
    logic [HAND_W-1:0] addr;
  } tbl_req_t;

  typedef struct packed {
    logic             is_replace;
    logic             writeback_needed;
    logic [IDX_W-1:0] victim_frame;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/clock_page_replacement.sv @@
// clock page replacement (enhanced second chance) over FRAMES frames
//
// in_*  : one request per transfer. func 0 replaces, 1 references a frame,
//         2 marks it dirty, 3 marks it clean, 4 releases it; other codes
//         change nothing. every request gives exactly one result on out_*.
// out_* : victim frame (or echoed frame_index), write-back flag, replace flag.
// flow:    a frame event goes to ST_DONE, which moves its result into the
//          output register once that is free; the sequencer then returns
//          to idle and takes the next request. a replace first walks the
//          clock hand one frame per cycle through the single compare unit,
//          visiting 1 to 3*FRAMES+1 frames (the fourth pass always hits its
//          first frame), and then finishes through ST_DONE the same way.
// in_tready is high only while the sequencer is idle; a finished result
// sits in the output register, so the next request is taken while it waits.
// if the receiver stalls with a result held and another result is ready,
// the sequencer waits and in_tready stays low.
// reset (rst_n low, synchronous) clears all valid and dirty bits, the hand
// and the output valid.
// depends on cpr_pkg, cpr_frame_table and cpr_ctrl
`default_nettype none

module clock_page_replacement
  import cpr_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // func[2:0], frame_index[7:3]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata   // victim_frame[4:0],
                                                  // writeback_needed[5],
                                                  // is_replace[6], zero[7]
);

  logic              out_valid_r;
  result_t           out_res_r;
  logic              out_free;
  logic              load_out;
  result_t           result;
  tbl_req_t          tbl_req;
  logic [HAND_W-1:0] rd_addr;
  logic              rd_valid;
  logic              rd_dirty;

  assign out_free = !out_valid_r || out_tready;

  cpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_func  (in_tdata[2:0]),
    .in_idx   (in_tdata[7:3]),
    .in_ready (in_tready),
    .out_free (out_free),
    .load_out (load_out),
    .result   (result),
    .tbl_req  (tbl_req),
    .rd_addr  (rd_addr),
    .rd_valid (rd_valid),
    .rd_dirty (rd_dirty)
  );

  cpr_frame_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (tbl_req),
    .rd_addr  (rd_addr),
    .rd_valid (rd_valid),
    .rd_dirty (rd_dirty)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.is_replace, out_res_r.writeback_needed,
                       out_res_r.victim_frame};

endmodule

`default_nettype wire

@@ rtl/cpr_frame_table.sv @@
// per-frame valid and dirty bits with one read port and one write command
// depends on cpr_pkg
`default_nettype none

module cpr_frame_table
  import cpr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tbl_req_t          req,
  input  wire logic [HAND_W-1:0] rd_addr,
  output logic                   rd_valid,
  output logic                   rd_dirty
);

  logic [FRAMES-1:0] valid_r, valid_nxt;
  logic [FRAMES-1:0] dirty_r, dirty_nxt;

  always_comb begin
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    case (req.cmd)
      TBL_SET_VALID: valid_nxt[req.addr] = 1'b1;
      TBL_SET_DIRTY: dirty_nxt[req.addr] = 1'b1;
      TBL_CLR_DIRTY: dirty_nxt[req.addr] = 1'b0;
      TBL_RELEASE: begin
        valid_nxt[req.addr] = 1'b0;
        dirty_nxt[req.addr] = 1'b0;
      end
      TBL_CLR_VALID: valid_nxt[req.addr] = 1'b0;
      TBL_LOAD: begin
        valid_nxt[req.addr] = 1'b1;
        dirty_nxt[req.addr] = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
    end
  end

  assign rd_valid = valid_r[rd_addr];
  assign rd_dirty = dirty_r[rd_addr];

endmodule

`default_nettype wire

@@ rtl/cpr_ctrl.sv @@
// sequencer: takes requests, walks the clock hand one frame per cycle on replace
// depends on cpr_pkg; drives cpr_frame_table through a tbl_req_t
`default_nettype none

module cpr_ctrl
  import cpr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [FUNC_W-1:0] in_func,
  input  wire logic [IDX_W-1:0]  in_idx,
  output logic                   in_ready,
  input  wire logic              out_free,
  output logic                   load_out,
  output result_t                result,
  output tbl_req_t               tbl_req,
  output logic [HAND_W-1:0]      rd_addr,
  input  wire logic              rd_valid,
  input  wire logic              rd_dirty
);

  localparam logic [HAND_W-1:0] LAST = HAND_W'(FRAMES - 1);

  state_t            state_r, state_nxt;
  logic [HAND_W-1:0] hand_r, hand_nxt;
  logic [HAND_W-1:0] step_r, step_nxt;
  logic [1:0]        pass_r, pass_nxt;
  result_t           res_r, res_nxt;

  logic accept;
  logic in_range;
  logic want_dirty;
  logic scan_hit;
  logic [HAND_W-1:0] hand_inc;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign in_range   = 32'(in_idx) < 32'(FRAMES);
  assign want_dirty = pass_r[0];
  assign rd_addr    = hand_r;
  // compare unit shared by all passes
  assign scan_hit   = !rd_valid && (rd_dirty == want_dirty);
  assign hand_inc   = (hand_r == LAST) ? '0 : hand_r + 1'b1;
  assign result     = res_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_func == FN_REPLACE) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    tbl_req.cmd  = TBL_NONE;
    tbl_req.addr = hand_r;
    load_out     = 1'b0;
    hand_nxt     = hand_r;
    step_nxt     = step_r;
    pass_nxt     = pass_r;
    res_nxt      = res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          step_nxt                 = '0;
          pass_nxt                 = '0;
          res_nxt.victim_frame     = in_idx;
          res_nxt.writeback_needed = 1'b0;
          res_nxt.is_replace       = (in_func == FN_REPLACE);
          tbl_req.addr             = HAND_W'(in_idx);
          if (in_range) begin
            case (in_func)
              FN_REFERENCE: tbl_req.cmd = TBL_SET_VALID;
              FN_DIRTY:     tbl_req.cmd = TBL_SET_DIRTY;
              FN_CLEANED:   tbl_req.cmd = TBL_CLR_DIRTY;
              FN_RELEASE:   tbl_req.cmd = TBL_RELEASE;
              default:      tbl_req.cmd = TBL_NONE;
            endcase
          end
        end
      end
      ST_SCAN: begin
        hand_nxt = hand_inc;
        if (scan_hit) begin
          tbl_req.cmd              = TBL_LOAD;
          res_nxt.victim_frame     = IDX_W'(hand_r);
          res_nxt.writeback_needed = rd_dirty;
        end else begin
          if (want_dirty) begin
            tbl_req.cmd = TBL_CLR_VALID;
          end
          if (step_r == LAST) begin
            step_nxt = '0;
            pass_nxt = pass_r + 1'b1;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      ST_DONE: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hand_r  <= '0;
      step_r  <= '0;
      pass_r  <= '0;
    end else begin
      state_r <= state_nxt;
      hand_r  <= hand_nxt;
      step_r  <= step_nxt;
      pass_r  <= pass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  a_replace_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FN_REPLACE) |=> (state_r == ST_SCAN))
    else $error("replace request did not start a scan");

  a_event_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func != FN_REPLACE) |=> (state_r == ST_DONE && !res_r.is_replace))
    else $error("frame event took the scan path");

  // after two passes every valid bit is clear, so pass four hits on its first frame
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && pass_r == 2'd3 && step_r == LAST) |-> scan_hit)
    else $error("scan ran past four passes");

  a_hit_moves_hand: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && scan_hit) |=>
      (state_r == ST_DONE && res_r.is_replace && hand_r == $past(hand_inc)))
    else $error("victim found but hand or result wrong");

endmodule

`default_nettype wire
